/* hdl/alcr_pkg.sv */
package alcr_pkg;

    localparam int CHAN_BITS  = 8;
    localparam int NUM_CHAN   = 3;
    localparam int COLOR_BITS = CHAN_BITS * NUM_CHAN;

    typedef logic [CHAN_BITS-1:0]              chan_t;
    typedef logic [NUM_CHAN-1:0][CHAN_BITS-1:0] color_t;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_STEP = 1'b1
    } op_t;

endpackage

/* hdl/alcr_if.sv */
interface alcr_cmd_if #(parameter int COORD_BITS = 12);

    logic                                   valid;
    logic                                   ready;
    logic                                   operation;
    logic signed [COORD_BITS-1:0]           start_x;
    logic signed [COORD_BITS-1:0]           start_y;
    logic signed [COORD_BITS-1:0]           end_x;
    logic signed [COORD_BITS-1:0]           end_y;
    logic        [alcr_pkg::COLOR_BITS-1:0] start_color;
    logic        [alcr_pkg::COLOR_BITS-1:0] end_color;

    modport source
    (
        output valid, operation, start_x, start_y, end_x, end_y, start_color, end_color,
        input  ready
    );

    modport sink
    (
        input  valid, operation, start_x, start_y, end_x, end_y, start_color, end_color,
        output ready
    );

endinterface

interface alcr_pix_if #(parameter int COORD_BITS = 12);

    logic                                   valid;
    logic                                   ready;
    logic signed [COORD_BITS-1:0]           pixel_a_x;
    logic signed [COORD_BITS-1:0]           pixel_a_y;
    logic        [alcr_pkg::COLOR_BITS-1:0] pixel_a_color;
    logic signed [COORD_BITS-1:0]           pixel_b_x;
    logic signed [COORD_BITS-1:0]           pixel_b_y;
    logic        [alcr_pkg::COLOR_BITS-1:0] pixel_b_color;
    logic                                   last_column;

    modport source
    (
        output valid, pixel_a_x, pixel_a_y, pixel_a_color,
        output pixel_b_x, pixel_b_y, pixel_b_color, last_column,
        input  ready
    );

    modport sink
    (
        input  valid, pixel_a_x, pixel_a_y, pixel_a_color,
        input  pixel_b_x, pixel_b_y, pixel_b_color, last_column,
        output ready
    );

endinterface

/* hdl/antialiased_line_color_raster_unit.sv */
// Antialiased line rasteriser with a colour gradient along the line.
// cmd channel (valid/ready): operation 0 loads two endpoints and two RGB 8:8:8
// colours; operation 1 asks for the next column of the loaded line.
// pix channel (valid/ready): one transfer per column with the lower pixel (A,
// weighted by 1-frac) and the upper pixel (B, weighted by frac), last_column
// flagging the final column. A load gives no output.
// One item is worked on at a time; cmd.ready is low meanwhile. A load with dx
// non-zero runs the slope division; a load with dx zero does not. A step with
// no active line is dropped.
// A column uses the shared radix-2 divider for the colour fraction, skipped on
// a zero-length line, then one shared 8 x (FRAC_BITS+1) multiplier over three
// lerp and six weighting passes. The result sits in an output register, so the
// next item is taken while it waits; if the receiver stalls, the following
// column is held internally until the output register frees up.
// Reset clears the sequencer, the active-line flag and the output valid.
module antialiased_line_color_raster_unit #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input logic       clk,
    input logic       rst_n,
    alcr_cmd_if.sink  cmd,
    alcr_pix_if.source pix
);

    localparam int CB      = COORD_BITS;
    localparam int FB      = FRAC_BITS;
    localparam int ACC_W   = CB + FB + 2;
    localparam int SLOPE_W = FB + 2;
    localparam int P_W     = FB + 1;
    localparam int CH_W    = alcr_pkg::CHAN_BITS;
    localparam int PROD_W  = CH_W + P_W;
    localparam int LAST_LERP  = alcr_pkg::NUM_CHAN - 1;
    localparam int LAST_SCALE = 2 * alcr_pkg::NUM_CHAN - 1;

    typedef enum logic [4:0]
    {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_LERP  = 5'b00100,
        S_SCALE = 5'b01000,
        S_DONE  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // control
    logic        line_active_reg;
    logic        load_mode_reg;
    logic        pix_valid_reg;
    logic [2:0]  cnt_reg;

    // line state
    logic                     steep_reg;
    logic                     rev_reg;
    logic signed [CB-1:0]     maj_start_reg;
    logic signed [CB-1:0]     maj_end_reg;
    logic signed [CB-1:0]     cur_maj_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [SLOPE_W-1:0] slope_reg;
    logic                     slope_neg_reg;
    alcr_pkg::color_t         color_from_reg;
    alcr_pkg::color_t         color_to_reg;

    // column work
    logic [FB-1:0]            frac_reg;
    logic [P_W-1:0]           p_reg;
    alcr_pkg::color_t         lerp_reg;
    alcr_pkg::color_t         col_a_reg;
    alcr_pkg::color_t         col_b_reg;
    logic signed [CB-1:0]     res_ax_reg, res_ay_reg, res_bx_reg, res_by_reg;
    logic                     res_last_reg;

    // output register
    logic signed [CB-1:0]     out_ax_reg, out_ay_reg, out_bx_reg, out_by_reg;
    alcr_pkg::color_t         out_ca_reg, out_cb_reg;
    logic                     out_last_reg;

    logic accept, is_step, is_load, out_free;

    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && cmd.ready;
    assign is_step   = accept && (cmd.operation == alcr_pkg::OP_STEP);
    assign is_load   = accept && (cmd.operation == alcr_pkg::OP_LOAD);
    assign out_free  = !pix_valid_reg || pix.ready;

    // ---- load geometry ----
    logic signed [CB:0]   dx0, dy0, adx0, ady0;
    logic                 steep;
    logic signed [CB-1:0] a_maj, a_min, b_maj, b_min;
    logic                 rev;
    logic signed [CB-1:0] lo_maj, lo_min, hi_maj, hi_min;
    logic signed [CB:0]   ldx, ldy, ldy_abs;

    always_comb
    begin
        dx0   = {cmd.end_x[CB-1], cmd.end_x} - {cmd.start_x[CB-1], cmd.start_x};
        dy0   = {cmd.end_y[CB-1], cmd.end_y} - {cmd.start_y[CB-1], cmd.start_y};
        adx0  = dx0[CB] ? -dx0 : dx0;
        ady0  = dy0[CB] ? -dy0 : dy0;
        steep = ady0 > adx0;
        a_maj = steep ? cmd.start_y : cmd.start_x;
        a_min = steep ? cmd.start_x : cmd.start_y;
        b_maj = steep ? cmd.end_y   : cmd.end_x;
        b_min = steep ? cmd.end_x   : cmd.end_y;
        rev    = a_maj > b_maj;
        lo_maj = rev ? b_maj : a_maj;
        lo_min = rev ? b_min : a_min;
        hi_maj = rev ? a_maj : b_maj;
        hi_min = rev ? a_min : b_min;
        ldx     = {hi_maj[CB-1], hi_maj} - {lo_maj[CB-1], lo_maj};
        ldy     = {hi_min[CB-1], hi_min} - {lo_min[CB-1], lo_min};
        ldy_abs = ldy[CB] ? -ldy : ldy;
    end

    // ---- column geometry ----
    logic [FB-1:0]        frac;
    logic [CB-1:0]        ipart, ipart_up;
    logic [CB-1:0]        len, pos;
    logic                 last;

    always_comb
    begin
        frac     = acc_reg[FB-1:0];
        ipart    = acc_reg[FB +: CB];
        ipart_up = ipart + 1'b1;
        len      = maj_end_reg - maj_start_reg;
        pos      = cur_maj_reg - maj_start_reg;
        last     = cur_maj_reg >= maj_end_reg;
    end

    // ---- shared divider ----
    logic                div_start, div_done;
    logic [CB-1:0]       div_numer, div_denom;
    logic [P_W-1:0]      div_q;
    logic [SLOPE_W-1:0]  q_ext;

    assign div_start = (is_load && ldx[CB-1:0] != '0) ||
                       (is_step && line_active_reg && len != '0);
    assign div_numer = is_load ? ldy_abs[CB-1:0] : pos;
    assign div_denom = is_load ? ldx[CB-1:0] : len;
    assign q_ext     = {1'b0, div_q};

    alcr_div #(
        .COORD_BITS (CB),
        .FRAC_BITS  (FB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .numer    (div_numer),
        .denom    (div_denom),
        .done     (div_done),
        .quotient (div_q)
    );

    // ---- shared multiplier ----
    alcr_pkg::color_t    c0, c1;
    logic [1:0]          lerp_idx, scale_idx;
    alcr_pkg::chan_t     ch_a, ch_b, diff, step_amt, lerp_val, scaled;
    logic                rising;
    logic [P_W-1:0]      wa;
    logic [CH_W-1:0]     mul_a;
    logic [P_W-1:0]      mul_b;
    logic [PROD_W-1:0]   prod;

    always_comb
    begin
        c0        = rev_reg ? color_to_reg : color_from_reg;
        c1        = rev_reg ? color_from_reg : color_to_reg;
        lerp_idx  = cnt_reg[1:0];
        scale_idx = cnt_reg[2:1];
        ch_a      = c0[lerp_idx];
        ch_b      = c1[lerp_idx];
        rising    = ch_b > ch_a;
        diff      = rising ? ch_b - ch_a : ch_a - ch_b;
        wa        = {1'b1, {FB{1'b0}}} - {1'b0, frac_reg};
        if (state_reg == S_SCALE)
        begin
            mul_a = lerp_reg[scale_idx];
            mul_b = cnt_reg[0] ? {1'b0, frac_reg} : wa;
        end
        else
        begin
            mul_a = diff;
            mul_b = p_reg;
        end
        prod     = PROD_W'(mul_a) * PROD_W'(mul_b);
        step_amt = prod[FB +: CH_W];
        lerp_val = rising ? ch_a + step_amt : ch_a - step_amt;
        scaled   = prod[FB +: CH_W];
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (div_start)
                    state_next = S_DIV;
                else if (is_step && line_active_reg)
                    state_next = S_LERP;
            end
            S_DIV:
            begin
                if (div_done)
                    state_next = load_mode_reg ? S_IDLE : S_LERP;
            end
            S_LERP:
            begin
                if (cnt_reg == 3'(LAST_LERP))
                    state_next = S_SCALE;
            end
            S_SCALE:
            begin
                if (cnt_reg == 3'(LAST_SCALE))
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            line_active_reg <= 1'b0;
            load_mode_reg   <= 1'b0;
            pix_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (is_load)
            begin
                line_active_reg <= 1'b1;
                load_mode_reg   <= 1'b1;
            end
            else if (is_step && line_active_reg)
            begin
                line_active_reg <= !last;
                load_mode_reg   <= 1'b0;
            end

            if (state_reg == S_LERP && cnt_reg == 3'(LAST_LERP))
                cnt_reg <= '0;
            else if (state_reg == S_LERP || state_reg == S_SCALE)
                cnt_reg <= cnt_reg + 1'b1;
            else
                cnt_reg <= '0;

            if (state_reg == S_DONE && out_free)
                pix_valid_reg <= 1'b1;
            else if (pix.ready)
                pix_valid_reg <= 1'b0;
        end
    end

    // ---- datapath ----
    always_ff @(posedge clk)
    begin
        if (is_load)
        begin
            steep_reg      <= steep;
            rev_reg        <= rev;
            maj_start_reg  <= lo_maj;
            maj_end_reg    <= hi_maj;
            cur_maj_reg    <= lo_maj;
            acc_reg        <= {{2{lo_min[CB-1]}}, lo_min, {FB{1'b0}}};
            slope_reg      <= {2'b01, {FB{1'b0}}};
            slope_neg_reg  <= ldy[CB];
            color_from_reg <= cmd.start_color;
            color_to_reg   <= cmd.end_color;
        end
        else if (is_step && line_active_reg)
        begin
            frac_reg     <= frac;
            p_reg        <= '0;
            res_last_reg <= last;
            if (steep_reg)
            begin
                res_ax_reg <= ipart;
                res_ay_reg <= cur_maj_reg;
                res_bx_reg <= ipart_up;
                res_by_reg <= cur_maj_reg;
            end
            else
            begin
                res_ax_reg <= cur_maj_reg;
                res_ay_reg <= ipart;
                res_bx_reg <= cur_maj_reg;
                res_by_reg <= ipart_up;
            end
            if (!last)
            begin
                cur_maj_reg <= cur_maj_reg + 1'b1;
                acc_reg     <= acc_reg + ACC_W'(slope_reg);
            end
        end

        if (state_reg == S_DIV && div_done)
        begin
            if (load_mode_reg)
                slope_reg <= slope_neg_reg ? -q_ext : q_ext;
            else
                p_reg <= div_q;
        end

        if (state_reg == S_LERP)
            lerp_reg[lerp_idx] <= lerp_val;

        if (state_reg == S_SCALE)
        begin
            if (cnt_reg[0])
                col_b_reg[scale_idx] <= scaled;
            else
                col_a_reg[scale_idx] <= scaled;
        end

        if (state_reg == S_DONE && out_free)
        begin
            out_ax_reg   <= res_ax_reg;
            out_ay_reg   <= res_ay_reg;
            out_bx_reg   <= res_bx_reg;
            out_by_reg   <= res_by_reg;
            out_ca_reg   <= col_a_reg;
            out_cb_reg   <= col_b_reg;
            out_last_reg <= res_last_reg;
        end
    end

    assign pix.valid         = pix_valid_reg;
    assign pix.pixel_a_x     = out_ax_reg;
    assign pix.pixel_a_y     = out_ay_reg;
    assign pix.pixel_a_color = out_ca_reg;
    assign pix.pixel_b_x     = out_bx_reg;
    assign pix.pixel_b_y     = out_by_reg;
    assign pix.pixel_b_color = out_cb_reg;
    assign pix.last_column   = out_last_reg;

    // ---- checks ----
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside the division state");

    a_idle_step_dropped: assert property (@(posedge clk) disable iff (!rst_n)
        (is_step && !line_active_reg) |=> state_reg == S_IDLE)
        else $error("step without an active line was not dropped");

    a_load_activates: assert property (@(posedge clk) disable iff (!rst_n)
        is_load |=> line_active_reg && state_reg != S_LERP)
        else $error("load did not arm the line");

    a_done_waits_on_output: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && !out_free) |=> state_reg == S_DONE && pix_valid_reg)
        else $error("column left the holding state while output was occupied");

endmodule

/* hdl/alcr_div.sv */
// Radix-2 restoring divider for numer <= denom, giving (numer << FRAC_BITS) / denom.
// The quotient is at most 2^FRAC_BITS, so FRAC_BITS + 1 steps suffice.
module alcr_div #(
    parameter int COORD_BITS = 12,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] numer,
    input  logic [COORD_BITS-1:0] denom,
    output logic                  done,
    output logic [FRAC_BITS:0]    quotient
);

    localparam int REM_W = COORD_BITS + 1;
    localparam int Q_W   = FRAC_BITS + 1;
    localparam int CNT_W = $clog2(FRAC_BITS + 2);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [REM_W-1:0] rem_reg;
    logic [REM_W-1:0] denom_reg;
    logic [Q_W-1:0]   quo_reg;

    logic [REM_W-1:0] diff;
    logic             ge;

    assign diff = rem_reg - denom_reg;
    assign ge   = rem_reg >= denom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(Q_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg   <= {1'b0, numer};
            denom_reg <= {1'b0, denom};
            quo_reg   <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? {diff[REM_W-2:0], 1'b0} : {rem_reg[REM_W-2:0], 1'b0};
            quo_reg <= {quo_reg[Q_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

module tb;

    localparam int     CB           = 12;
    localparam int     FRAC         = 16;
    localparam longint ONE          = longint'(1) << FRAC;
    localparam int     RANDOM_ITEMS = 1150;

    typedef logic signed [CB-1:0]            coord_t;
    typedef logic [alcr_pkg::COLOR_BITS-1:0] rgb_t;

    typedef struct packed {
        coord_t ax;
        coord_t ay;
        rgb_t   acol;
        coord_t bx;
        coord_t by;
        rgb_t   bcol;
        logic   last_col;
    } column_t;

    typedef struct {
        alcr_pkg::op_t op;
        coord_t  sx;
        coord_t  sy;
        coord_t  ex;
        coord_t  ey;
        rgb_t    sc;
        rgb_t    ec;
        bit      typed;
        bit      yields;
        column_t want;
    } cmd_row_t;

    logic clk;
    logic rst_n;

    alcr_cmd_if #(.COORD_BITS(CB)) cmd ();
    alcr_pix_if #(.COORD_BITS(CB)) pix ();

    antialiased_line_color_raster_unit #(
        .COORD_BITS(CB),
        .FRAC_BITS (FRAC)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd),
        .pix  (pix)
    );

    // line state mirrored from the block
    bit      ln_steep;
    bit      ln_rev;
    bit      ln_active;
    int      maj_start;
    int      maj_end;
    int      maj_cur;
    longint  minor_acc;
    longint  slope;
    rgb_t    col_from;
    rgb_t    col_to;

    column_t columns_due[$];
    int      errors;
    int      items_done;
    int      phase;
    int      idle_pct[4]  = '{0, 45, 0, 11};
    int      stall_pct[4] = '{0, 0, 45, 11};

    always #2 clk = ~clk;

    function automatic rgb_t tint(input rgb_t c0, input rgb_t c1, input longint p,
                                  input longint w);
        longint a;
        longint b;
        longint ch;
        rgb_t   res;
        res = '0;
        for (int k = 0; k < alcr_pkg::NUM_CHAN; k++)
        begin
            a = c0[alcr_pkg::CHAN_BITS*k +: alcr_pkg::CHAN_BITS];
            b = c1[alcr_pkg::CHAN_BITS*k +: alcr_pkg::CHAN_BITS];
            if (b >= a)
                ch = a + (((b - a) * p) >> FRAC);
            else
                ch = a - (((a - b) * p) >> FRAC);
            res[alcr_pkg::CHAN_BITS*k +: alcr_pkg::CHAN_BITS] =
                alcr_pkg::chan_t'((ch * w) >> FRAC);
        end
        return res;
    endfunction

    function automatic void load_line(input cmd_row_t r);
        int sx;
        int sy;
        int ex;
        int ey;
        int t;
        sx = r.sx;
        sy = r.sy;
        ex = r.ex;
        ey = r.ey;
        ln_steep = (ey > sy ? ey - sy : sy - ey) > (ex > sx ? ex - sx : sx - ex);
        if (ln_steep)
        begin
            t = sx; sx = sy; sy = t;
            t = ex; ex = ey; ey = t;
        end
        ln_rev = sx > ex;
        if (ln_rev)
        begin
            t = sx; sx = ex; ex = t;
            t = sy; sy = ey; ey = t;
        end
        slope     = (ex == sx) ? ONE : (longint'(ey - sy) * ONE) / longint'(ex - sx);
        maj_start = sx;
        maj_end   = ex;
        maj_cur   = sx;
        minor_acc = longint'(sy) * ONE;
        col_from  = r.sc;
        col_to    = r.ec;
        ln_active = 1'b1;
    endfunction

    // one column of the active line; returns 0 when no line is running
    function automatic bit next_column(output column_t c);
        longint frac;
        longint ipart;
        longint len;
        longint pos;
        longint p;
        rgb_t   c0;
        rgb_t   c1;
        coord_t maj;
        coord_t mina;
        coord_t minb;
        c = '0;
        if (!ln_active)
            return 1'b0;
        frac  = minor_acc & (ONE - 1);
        ipart = (minor_acc - frac) / ONE;
        len   = maj_end - maj_start;
        pos   = maj_cur - maj_start;
        p     = (len == 0) ? 0 : (pos << FRAC) / len;
        c0    = ln_rev ? col_to : col_from;
        c1    = ln_rev ? col_from : col_to;
        maj   = coord_t'(maj_cur);
        mina  = coord_t'(ipart);
        minb  = coord_t'(ipart + 1);
        if (ln_steep)
        begin
            c.ax = mina; c.ay = maj;
            c.bx = minb; c.by = maj;
        end
        else
        begin
            c.ax = maj; c.ay = mina;
            c.bx = maj; c.by = minb;
        end
        c.acol     = tint(c0, c1, p, ONE - frac);
        c.bcol     = tint(c0, c1, p, frac);
        c.last_col = maj_cur >= maj_end;
        if (c.last_col)
            ln_active = 1'b0;
        else
        begin
            maj_cur++;
            minor_acc += slope;
        end
        return 1'b1;
    endfunction

    function automatic cmd_row_t step_row();
        cmd_row_t r;
        // coordinates and colours are don't-care on a step, so fill with junk
        r.op     = alcr_pkg::OP_STEP;
        r.sx     = coord_t'($urandom);
        r.sy     = coord_t'($urandom);
        r.ex     = coord_t'($urandom);
        r.ey     = coord_t'($urandom);
        r.sc     = rgb_t'($urandom);
        r.ec     = rgb_t'($urandom);
        r.typed  = 1'b0;
        r.yields = 1'b0;
        r.want   = '0;
        return r;
    endfunction

    function automatic cmd_row_t load_row(input coord_t sx, sy, ex, ey, input rgb_t sc, ec);
        cmd_row_t r;
        r    = step_row();
        r.op = alcr_pkg::OP_LOAD;
        r.sx = sx;
        r.sy = sy;
        r.ex = ex;
        r.ey = ey;
        r.sc = sc;
        r.ec = ec;
        return r;
    endfunction

    function automatic cmd_row_t quiet_row();
        cmd_row_t r;
        r       = step_row();
        r.typed = 1'b1;
        return r;
    endfunction

    function automatic cmd_row_t pixel_row(input coord_t ax, ay, input rgb_t acol,
                                           input coord_t bx, by, input rgb_t bcol,
                                           input logic last_col);
        cmd_row_t r;
        r        = step_row();
        r.typed  = 1'b1;
        r.yields = 1'b1;
        r.want   = '{ax, ay, acol, bx, by, bcol, last_col};
        return r;
    endfunction

    task automatic issue(input cmd_row_t r);
        column_t c;
        bit      got;
        phase = (items_done / 150) % 4;
        while ($urandom_range(99) < idle_pct[phase])
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid       <= 1'b1;
        cmd.operation   <= r.op;
        cmd.start_x     <= r.sx;
        cmd.start_y     <= r.sy;
        cmd.end_x       <= r.ex;
        cmd.end_y       <= r.ey;
        cmd.start_color <= r.sc;
        cmd.end_color   <= r.ec;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
        if (r.op == alcr_pkg::OP_LOAD)
        begin
            load_line(r);
            items_done++;
        end
        else
        begin
            got = next_column(c);
            if (got)
                items_done++;
            if (r.typed ? r.yields : got)
                columns_due.push_back(r.typed ? r.want : c);
        end
    endtask

    // output side: check each transfer, then pick the next ready
    always @(posedge clk)
    begin
        column_t got;
        column_t want;
        if (rst_n && pix.valid && pix.ready)
        begin
            got = '{pix.pixel_a_x, pix.pixel_a_y, pix.pixel_a_color,
                    pix.pixel_b_x, pix.pixel_b_y, pix.pixel_b_color, pix.last_column};
            if (columns_due.size() == 0)
            begin
                if (errors < 10)
                    $display("unexpected column A(%0d,%0d) B(%0d,%0d)",
                             got.ax, got.ay, got.bx, got.by);
                errors++;
            end
            else
            begin
                want = columns_due.pop_front();
                if (got.ax !== want.ax || got.ay !== want.ay || got.acol !== want.acol ||
                    got.bx !== want.bx || got.by !== want.by || got.bcol !== want.bcol ||
                    got.last_col !== want.last_col)
                begin
                    if (errors < 10)
                        $display({"column mismatch: expected A(%0d,%0d) %06h B(%0d,%0d) %06h",
                                  " last %0b, got A(%0d,%0d) %06h B(%0d,%0d) %06h last %0b"},
                                 want.ax, want.ay, want.acol, want.bx, want.by, want.bcol,
                                 want.last_col, got.ax, got.ay, got.acol, got.bx, got.by,
                                 got.bcol, got.last_col);
                    errors++;
                end
            end
        end
        pix.ready <= ($urandom_range(99) >= stall_pct[phase]);
    end

    initial
    begin
        #2_000_000;
        $display("tb failed");
        $finish;
    end

    initial
    begin
        cmd_row_t opening[$];
        cmd_row_t r;
        int       target;
        int       kind;
        int       x0;
        int       y0;
        int       x1;
        int       y1;
        int       dx;
        int       dy;
        int       nsteps;
        int       pick;

        clk             = 1'b0;
        rst_n           = 1'b0;
        cmd.valid       = 1'b0;
        cmd.operation   = alcr_pkg::OP_LOAD;
        cmd.start_x     = '0;
        cmd.start_y     = '0;
        cmd.end_x       = '0;
        cmd.end_y       = '0;
        cmd.start_color = '0;
        cmd.end_color   = '0;
        pix.ready       = 1'b0;
        errors          = 0;
        items_done      = 0;
        phase           = 0;
        ln_steep        = 1'b0;
        ln_rev          = 1'b0;
        ln_active       = 1'b0;
        maj_start       = 0;
        maj_end         = 0;
        maj_cur         = 0;
        minor_acc       = 0;
        slope           = 0;
        col_from        = '0;
        col_to          = '0;

        opening = '{
            // step before any line: dropped
            quiet_row(),
            // single point: slope 1, zero length, fraction 0
            load_row(0, 0, 0, 0, 24'hFFFFFF, 24'h000000),
            pixel_row(0, 0, 24'hFFFFFF, 0, 1, 24'h000000, 1'b1),
            quiet_row(),
            // full-width horizontal at top row: upper pixel wraps
            load_row(-2048, 2047, 2047, 2047, 24'hA5C3E1, 24'h5A3C1E),
            pixel_row(-2048, 2047, 24'hA5C3E1, -2048, -2048, 24'h000000, 1'b0),
            step_row(),
            // reversed endpoints replace the line in progress
            load_row(2047, -2048, -2048, -2048, 24'h000000, 24'hFFFFFF),
            pixel_row(-2048, -2048, 24'hFFFFFF, -2048, -2047, 24'h000000, 1'b0),
            // vertical: steep, dx of zero after the exchange is not hit
            load_row(5, -2048, 5, 2047, 24'h00FF00, 24'hFF00FF),
            pixel_row(5, -2048, 24'h00FF00, 6, -2048, 24'h000000, 1'b0),
            step_row(),
            // short steep line with a fractional slope
            load_row(-3, -3, 3, 4, 24'h102030, 24'hF0E0D0),
            step_row(), step_row(), step_row(), step_row(),
            // steep and reversed
            load_row(10, 1, 7, -9, 24'h0000FF, 24'hFF0000),
            step_row(), step_row(), step_row(),
            // shallow, falling, channels differing by one
            load_row(0, 0, 5, -2, 24'h808080, 24'h7F7F7F),
            step_row(), step_row(), step_row()
        };

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
            issue(opening[i]);

        target = items_done + RANDOM_ITEMS;
        while (items_done < target)
        begin
            if ($urandom_range(19) == 0)
                issue(step_row());
            kind = $urandom_range(99);
            x0   = int'($urandom_range(4095)) - 2048;
            y0   = int'($urandom_range(4095)) - 2048;
            if (kind < 8)
            begin
                // arbitrary endpoints, cut short by the next load
                x1     = int'($urandom_range(4095)) - 2048;
                y1     = int'($urandom_range(4095)) - 2048;
                nsteps = $urandom_range(1, 12);
            end
            else
            begin
                dx = int'($urandom_range(48)) - 24;
                dy = int'($urandom_range(48)) - 24;
                pick = $urandom_range(11);
                if (pick == 0)
                    dx = 0;
                else if (pick == 1)
                    dy = 0;
                else if (pick == 2)
                begin
                    dx = 0;
                    dy = 0;
                end
                x1 = x0 + dx;
                if (x1 > 2047 || x1 < -2048)
                    x1 = x0 - dx;
                y1 = y0 + dy;
                if (y1 > 2047 || y1 < -2048)
                    y1 = y0 - dy;
                nsteps = ((dx < 0 ? -dx : dx) > (dy < 0 ? -dy : dy) ?
                          (dx < 0 ? -dx : dx) : (dy < 0 ? -dy : dy)) + 1;
                pick = $urandom_range(9);
                if (pick == 0)
                    nsteps = $urandom_range(0, nsteps - 1);
                else if (pick == 1)
                    nsteps += $urandom_range(1, 2);
            end
            r    = load_row(coord_t'(x0), coord_t'(y0), coord_t'(x1), coord_t'(y1),
                            rgb_t'($urandom), rgb_t'($urandom));
            pick = $urandom_range(19);
            if (pick == 0)
                r.ec = r.sc;
            else if (pick == 1)
            begin
                r.sc = '0;
                r.ec = '1;
            end
            else if (pick == 2)
            begin
                r.sc = '1;
                r.ec = '0;
            end
            issue(r);
            repeat (nsteps)
                issue(step_row());
        end
        cmd.valid <= 1'b0;

        for (int n = 0; n < 4000 && columns_due.size() != 0; n++)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (columns_due.size() != 0)
        begin
            if (errors < 10)
                $display("%0d expected columns never arrived", columns_due.size());
            errors += columns_due.size();
        end
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
